FILE: rtl/pte_pkg.sv
// Shared types, constants and trig helper functions for the primitive triangle expander.
package pte_pkg;

    // Default build configuration.
    localparam int PTE_ANGLE_STEP_DEG = 10;
    localparam int PTE_CORDIC_STEPS   = 16;
    localparam int PTE_FRACTION_BITS  = 16;

    // CORDIC datapath widths: vector lanes hold line deltas scaled by 2^20 plus gain growth.
    localparam int CORDIC_W   = 56;
    localparam int ANGLE_W    = 35;
    localparam int LINE_SCALE = 20;
    // Bits of a rotation result that carry the Q30 sine or cosine.
    localparam int TRIG_W     = 34;

    // Angles are signed Q5.30 radians.
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    typedef enum logic [1:0] {
        OP_LINE   = 2'd0,
        OP_RECT   = 2'd1,
        OP_CIRCLE = 2'd2,
        OP_NONE   = 2'd3
    } pte_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_VEC_WAIT,
        ST_FOLD,
        ST_ROT_WAIT,
        ST_ROUND,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_PRIME,
        ST_LOAD,
        ST_EMIT
    } pte_state_t;

    // Command from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic start;
        logic rotate;
    } pte_cordic_ctrl_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [29:0] pte_atan(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837829;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021687;
            5'd5:    val = 30'd33543516;
            5'd6:    val = 30'd16775851;
            5'd7:    val = 30'd8388437;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

    // Sine or cosine of a whole number of degrees, evaluated at elaboration with the
    // same rotation-mode CORDIC as the hardware, rounded to fb fraction bits.
    function automatic longint pte_trig_deg(input int deg, input int iters, input int fb,
                                            input bit want_sin);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint res;
        int     d;
        int     sh;
        int     i;
        bit     neg;
        d   = (deg > 180) ? deg - 360 : deg;
        z   = (longint'(d) * PI_Q30) / 180;
        x   = GAIN_Q30;
        y   = 0;
        neg = 1'b0;
        sh  = 30 - fb;
        if (z > HALF_PI_Q30) begin
            z   = z - PI_Q30;
            neg = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z   = z + PI_Q30;
            neg = 1'b1;
        end
        for (i = 0; i < iters; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(pte_atan(5'(i)));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(pte_atan(5'(i)));
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        res = want_sin ? y : x;
        return (res + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

endpackage

FILE: rtl/pte_cordic.sv
// Shared CORDIC unit: one micro-rotation per cycle in vectoring or rotation mode.
module pte_cordic
    import pte_pkg::*;
#(
    parameter int CORDIC_STEPS = PTE_CORDIC_STEPS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pte_cordic_ctrl_t           ctrl,
    input  logic signed [CORDIC_W-1:0] x_init,
    input  logic signed [CORDIC_W-1:0] y_init,
    input  logic signed [ANGLE_W-1:0]  z_init,
    output logic signed [CORDIC_W-1:0] x,
    output logic signed [CORDIC_W-1:0] y,
    output logic signed [ANGLE_W-1:0]  z,
    output logic                       done
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;
    logic [IW-1:0]              iter_reg;
    logic                       busy_reg;
    logic                       rot_reg;
    logic                       done_reg;

    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [ANGLE_W-1:0]  atan_z;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [ANGLE_W-1:0]  z_next;
    logic                       turn_pos;
    logic                       last_iter;

    // One micro-rotation. Rotation mode drives z toward zero, vectoring mode drives y.
    always_comb
    begin
        x_sh      = x_reg >>> iter_reg;
        y_sh      = y_reg >>> iter_reg;
        atan_z    = ANGLE_W'(pte_atan(5'(iter_reg)));
        turn_pos  = rot_reg ? !z_reg[ANGLE_W-1] : (y_reg[CORDIC_W-1] || (y_reg == '0));
        last_iter = (iter_reg == IW'(CORDIC_STEPS - 1));
        if (turn_pos)
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_z;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_z;
        end
    end

    // Vector and angle registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            rot_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                iter_reg <= '0;
                busy_reg <= 1'b1;
                rot_reg  <= ctrl.rotate;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

FILE: rtl/pte_mult.sv
// Shared scaling multiplier: registered product, then round and shift to a Q16.16 offset.
module pte_mult
    import pte_pkg::*;
#(
    parameter int FRACTION_BITS = PTE_FRACTION_BITS
) (
    input  logic                           clk,
    input  logic [30:0]                    a,
    input  logic signed [FRACTION_BITS+1:0] b,
    input  logic                           line_mode,
    output logic signed [31:0]             res
);

    localparam int PW = 32 + FRACTION_BITS + 2;
    localparam logic signed [PW:0] RND_LINE = (PW + 1)'(1) << FRACTION_BITS;
    localparam logic signed [PW:0] RND_CIRC = (PW + 1)'(1) << (FRACTION_BITS - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   sum;
    logic signed [PW:0]   shifted;

    // Unsigned length times signed trig value.
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, a}) * b;
    end

    // Line half-thickness rounds at F+1 bits, circle radius terms at F bits.
    always_comb
    begin
        sum     = {prod_reg[PW-1], prod_reg} + (line_mode ? RND_LINE : RND_CIRC);
        shifted = line_mode ? (sum >>> (FRACTION_BITS + 1)) : (sum >>> FRACTION_BITS);
        res     = shifted[31:0];
    end

endmodule

FILE: rtl/primitive_triangle_expander_unit.sv
// Top level of the primitive triangle expander: sequencer, operand registers and outputs.
//
// Takes one primitive transaction (thick line, rectangle or circle) and returns it as a
// stream of triangle transactions, with last_triangle set on the final one. The block
// handles one primitive at a time: in_ready is high only while it is idle. A rectangle
// returns two triangles. A thick line runs the shared CORDIC unit twice, first to find
// the line angle and then its sine and cosine (a zero-length line skips the first pass).
// A circle reads its sine and cosine from a constant table and uses the shared
// multiplier twice per wedge. Output stalls while out_ready is held low. Operation
// code 3 is accepted and returns no triangles.
module primitive_triangle_expander_unit
    import pte_pkg::*;
#(
    parameter int ANGLE_STEP_DEG = PTE_ANGLE_STEP_DEG,
    parameter int CORDIC_STEPS   = PTE_CORDIC_STEPS,
    parameter int FRACTION_BITS  = PTE_FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] x_a,
    input  logic signed [31:0] y_a,
    input  logic signed [31:0] x_b,
    input  logic signed [31:0] y_b,
    input  logic [30:0]        rect_width,
    input  logic [30:0]        rect_height,
    input  logic [30:0]        circle_radius,
    input  logic [30:0]        line_thickness,
    input  logic [31:0]        packed_color,
    input  logic [7:0]         alpha_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] corner_a_x,
    output logic signed [31:0] corner_a_y,
    output logic signed [31:0] corner_b_x,
    output logic signed [31:0] corner_b_y,
    output logic signed [31:0] corner_c_x,
    output logic signed [31:0] corner_c_y,
    output logic [31:0]        vertex_color,
    output logic [7:0]         vertex_alpha,
    output logic               last_triangle
);

    localparam int TW      = FRACTION_BITS + 2;
    localparam int N_WEDGE = (360 + ANGLE_STEP_DEG - 1) / ANGLE_STEP_DEG;
    localparam int WW      = $clog2(N_WEDGE + 1);

    localparam logic signed [ANGLE_W-1:0]  PI_Z      = ANGLE_W'(PI_Q30);
    localparam logic signed [ANGLE_W-1:0]  HALF_PI_Z = ANGLE_W'(HALF_PI_Q30);
    localparam logic signed [CORDIC_W-1:0] GAIN_X    = CORDIC_W'(GAIN_Q30);
    localparam logic signed [TRIG_W:0]     HALF_LSB  = (TRIG_W + 1)'(1) << (29 - FRACTION_BITS);

    // Sequencer state and operand registers.
    pte_state_t          state_reg;
    pte_state_t          state_next;
    pte_op_t             op_reg;
    logic signed [31:0]  xa_reg;
    logic signed [31:0]  ya_reg;
    logic signed [31:0]  xb_reg;
    logic signed [31:0]  yb_reg;
    logic [30:0]         w_reg;
    logic [30:0]         h_reg;
    logic [30:0]         r_reg;
    logic [30:0]         t_reg;
    logic [31:0]         color_reg;
    logic [7:0]          alpha_reg;
    logic                neg_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [31:0]  offc_reg;
    logic signed [31:0]  offs_reg;
    logic signed [31:0]  old_x_reg;
    logic signed [31:0]  old_y_reg;
    logic [WW-1:0]       wedge_reg;
    logic                tri_reg;

    // Output registers.
    logic signed [31:0]  ax_reg;
    logic signed [31:0]  ay_reg;
    logic signed [31:0]  bx_reg;
    logic signed [31:0]  by_reg;
    logic signed [31:0]  cx_reg;
    logic signed [31:0]  cy_reg;
    logic                last_reg;

    // Constant sine and cosine table for the circle fan, one entry per wedge edge.
    logic signed [TW-1:0] cos_tab [N_WEDGE+1];
    logic signed [TW-1:0] sin_tab [N_WEDGE+1];

    for (genvar k = 0; k <= N_WEDGE; k++)
    begin : g_trig
        localparam int     DEG   = (k * ANGLE_STEP_DEG > 360) ? 360 : k * ANGLE_STEP_DEG;
        localparam longint COS_V = pte_trig_deg(DEG, CORDIC_STEPS, FRACTION_BITS, 1'b0);
        localparam longint SIN_V = pte_trig_deg(DEG, CORDIC_STEPS, FRACTION_BITS, 1'b1);
        assign cos_tab[k] = COS_V[TW-1:0];
        assign sin_tab[k] = SIN_V[TW-1:0];
    end

    // Shared units.
    pte_cordic_ctrl_t           cordic_ctrl;
    logic signed [CORDIC_W-1:0] cordic_x_init;
    logic signed [CORDIC_W-1:0] cordic_y_init;
    logic signed [ANGLE_W-1:0]  cordic_z_init;
    logic signed [CORDIC_W-1:0] cordic_x;
    logic signed [CORDIC_W-1:0] cordic_y;
    logic signed [ANGLE_W-1:0]  cordic_z;
    logic                       cordic_done;

    logic [30:0]                mul_a;
    logic signed [TW-1:0]       mul_b;
    logic                       mul_line;
    logic signed [31:0]         mul_res;

    pte_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cordic_ctrl),
        .x_init (cordic_x_init),
        .y_init (cordic_y_init),
        .z_init (cordic_z_init),
        .x      (cordic_x),
        .y      (cordic_y),
        .z      (cordic_z),
        .done   (cordic_done)
    );

    pte_mult #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mult (
        .clk       (clk),
        .a         (mul_a),
        .b         (mul_b),
        .line_mode (mul_line),
        .res       (mul_res)
    );

    logic in_accept;
    logic out_accept;
    logic is_circle;
    logic wedge_last;

    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;
    assign is_circle  = (op_reg == OP_CIRCLE);
    assign wedge_last = (wedge_reg == WW'(N_WEDGE));

    // Line direction, with the vector turned into the right half plane when dx is negative.
    logic signed [32:0] dx_pos;
    logic signed [32:0] dx_neg;
    logic signed [32:0] dy_pos;
    logic signed [32:0] dy_neg;
    logic signed [32:0] vec_x;
    logic signed [32:0] vec_y;
    logic signed [ANGLE_W-1:0] vec_z;
    logic               line_zero;

    always_comb
    begin
        dx_pos    = {xb_reg[31], xb_reg} - {xa_reg[31], xa_reg};
        dx_neg    = {xa_reg[31], xa_reg} - {xb_reg[31], xb_reg};
        dy_pos    = {yb_reg[31], yb_reg} - {ya_reg[31], ya_reg};
        dy_neg    = {ya_reg[31], ya_reg} - {yb_reg[31], yb_reg};
        line_zero = (dx_pos == '0) && (dy_pos == '0);
        if (dx_pos[32])
        begin
            vec_x = dx_neg;
            vec_y = dy_neg;
            vec_z = dy_pos[32] ? -PI_Z : PI_Z;
        end
        else
        begin
            vec_x = dx_pos;
            vec_y = dy_pos;
            vec_z = '0;
        end
    end

    // Fold the line angle into the half circle that the rotation covers.
    logic signed [ANGLE_W-1:0] z_fold;
    logic                      fold_neg;

    always_comb
    begin
        if (cordic_z > HALF_PI_Z)
        begin
            z_fold   = cordic_z - PI_Z;
            fold_neg = 1'b1;
        end
        else if (cordic_z < -HALF_PI_Z)
        begin
            z_fold   = cordic_z + PI_Z;
            fold_neg = 1'b1;
        end
        else
        begin
            z_fold   = cordic_z;
            fold_neg = 1'b0;
        end
    end

    // Round the Q30 rotation results to the trig fraction width, negating when folded.
    logic signed [TRIG_W-1:0] cos_raw;
    logic signed [TRIG_W-1:0] sin_raw;
    logic signed [TRIG_W:0]   cos_rnd;
    logic signed [TRIG_W:0]   sin_rnd;
    logic signed [TRIG_W:0]   cos_q;
    logic signed [TRIG_W:0]   sin_q;
    logic signed [TW-1:0]     cos_next;
    logic signed [TW-1:0]     sin_next;

    always_comb
    begin
        cos_raw  = cordic_x[TRIG_W-1:0];
        sin_raw  = cordic_y[TRIG_W-1:0];
        cos_rnd  = neg_reg ? (HALF_LSB - cos_raw) : (cos_raw + HALF_LSB);
        sin_rnd  = neg_reg ? (HALF_LSB - sin_raw) : (sin_raw + HALF_LSB);
        cos_q    = cos_rnd >>> (30 - FRACTION_BITS);
        sin_q    = sin_rnd >>> (30 - FRACTION_BITS);
        cos_next = cos_q[TW-1:0];
        sin_next = sin_q[TW-1:0];
    end

    // Multiplier operands: thickness or radius times cosine, then times sine.
    always_comb
    begin
        mul_line = !is_circle;
        mul_a    = is_circle ? r_reg : t_reg;
        if (state_reg == ST_MUL_A)
        begin
            mul_b = is_circle ? cos_tab[wedge_reg] : cos_reg;
        end
        else
        begin
            mul_b = is_circle ? sin_tab[wedge_reg] : sin_reg;
        end
    end

    // Triangle assembly for the output registers.
    logic signed [31:0] w_s;
    logic signed [31:0] h_s;
    logic signed [31:0] tri_ax;
    logic signed [31:0] tri_ay;
    logic signed [31:0] tri_bx;
    logic signed [31:0] tri_by;
    logic signed [31:0] tri_cx;
    logic signed [31:0] tri_cy;
    logic               tri_last;

    always_comb
    begin
        w_s = $signed({1'b0, w_reg});
        h_s = $signed({1'b0, h_reg});
        case (op_reg)
            OP_LINE:
            begin
                tri_last = tri_reg;
                if (!tri_reg)
                begin
                    tri_ax = xa_reg + offs_reg;
                    tri_ay = ya_reg - offc_reg;
                    tri_bx = xb_reg + offs_reg;
                    tri_by = yb_reg - offc_reg;
                    tri_cx = xb_reg - offs_reg;
                    tri_cy = yb_reg + offc_reg;
                end
                else
                begin
                    tri_ax = xb_reg - offs_reg;
                    tri_ay = yb_reg + offc_reg;
                    tri_bx = xa_reg - offs_reg;
                    tri_by = ya_reg + offc_reg;
                    tri_cx = xa_reg + offs_reg;
                    tri_cy = ya_reg - offc_reg;
                end
            end
            OP_RECT:
            begin
                tri_last = tri_reg;
                if (!tri_reg)
                begin
                    tri_ax = xa_reg;
                    tri_ay = ya_reg;
                    tri_bx = xa_reg + w_s;
                    tri_by = ya_reg;
                    tri_cx = xa_reg;
                    tri_cy = ya_reg + h_s;
                end
                else
                begin
                    tri_ax = xa_reg;
                    tri_ay = ya_reg + h_s;
                    tri_bx = xa_reg + w_s;
                    tri_by = ya_reg;
                    tri_cx = xa_reg + w_s;
                    tri_cy = ya_reg + h_s;
                end
            end
            default:
            begin
                // Circle wedge: centre, new edge point, previous edge point.
                tri_last = wedge_last;
                tri_ax   = xa_reg;
                tri_ay   = ya_reg;
                tri_bx   = xa_reg + offc_reg;
                tri_by   = ya_reg + offs_reg;
                tri_cx   = old_x_reg;
                tri_cy   = old_y_reg;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and CORDIC commands.
    always_comb
    begin
        state_next         = state_reg;
        cordic_ctrl.start  = 1'b0;
        cordic_ctrl.rotate = 1'b0;
        cordic_x_init      = GAIN_X;
        cordic_y_init      = '0;
        cordic_z_init      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_LINE:   state_next = ST_SETUP;
                        OP_RECT:   state_next = ST_LOAD;
                        OP_CIRCLE: state_next = ST_MUL_A;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP:
            begin
                cordic_ctrl.start = 1'b1;
                if (line_zero)
                begin
                    // Zero-length line: angle zero, straight to the rotation pass.
                    cordic_ctrl.rotate = 1'b1;
                    state_next         = ST_ROT_WAIT;
                end
                else
                begin
                    cordic_x_init = {{(CORDIC_W-33-LINE_SCALE){vec_x[32]}}, vec_x,
                                     {LINE_SCALE{1'b0}}};
                    cordic_y_init = {{(CORDIC_W-33-LINE_SCALE){vec_y[32]}}, vec_y,
                                     {LINE_SCALE{1'b0}}};
                    cordic_z_init = vec_z;
                    state_next    = ST_VEC_WAIT;
                end
            end
            ST_VEC_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cordic_ctrl.start  = 1'b1;
                cordic_ctrl.rotate = 1'b1;
                cordic_z_init      = z_fold;
                state_next         = ST_ROT_WAIT;
            end
            ST_ROT_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                state_next = (is_circle && (wedge_reg == '0)) ? ST_PRIME : ST_LOAD;
            end
            ST_PRIME:
            begin
                state_next = ST_MUL_A;
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = is_circle ? ST_MUL_A : ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Triangle and wedge counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wedge_reg <= '0;
            tri_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                wedge_reg <= '0;
                tri_reg   <= 1'b0;
            end
            else if (state_reg == ST_PRIME)
            begin
                wedge_reg <= WW'(1);
            end
            else if (out_accept && !last_reg)
            begin
                tri_reg <= 1'b1;
                if (is_circle)
                begin
                    wedge_reg <= wedge_reg + 1'b1;
                end
            end
        end
    end

    // Operand capture and datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= pte_op_t'(operation);
            xa_reg    <= x_a;
            ya_reg    <= y_a;
            xb_reg    <= x_b;
            yb_reg    <= y_b;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            r_reg     <= circle_radius;
            t_reg     <= line_thickness;
            color_reg <= packed_color;
            alpha_reg <= alpha_value;
        end
        if (state_reg == ST_SETUP)
        begin
            neg_reg <= 1'b0;
        end
        if (state_reg == ST_FOLD)
        begin
            neg_reg <= fold_neg;
        end
        if (state_reg == ST_ROUND)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (state_reg == ST_MUL_B)
        begin
            offc_reg <= mul_res;
        end
        if (state_reg == ST_MUL_C)
        begin
            offs_reg <= mul_res;
        end
        if (state_reg == ST_PRIME)
        begin
            old_x_reg <= xa_reg + offc_reg;
            old_y_reg <= ya_reg + offs_reg;
        end
        else if (out_accept)
        begin
            old_x_reg <= bx_reg;
            old_y_reg <= by_reg;
        end
        if (state_reg == ST_LOAD)
        begin
            ax_reg   <= tri_ax;
            ay_reg   <= tri_ay;
            bx_reg   <= tri_bx;
            by_reg   <= tri_by;
            cx_reg   <= tri_cx;
            cy_reg   <= tri_cy;
            last_reg <= tri_last;
        end
    end

    // Port drive.
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = (state_reg == ST_EMIT);
    assign corner_a_x    = ax_reg;
    assign corner_a_y    = ay_reg;
    assign corner_b_x    = bx_reg;
    assign corner_b_y    = by_reg;
    assign corner_c_x    = cx_reg;
    assign corner_c_y    = cy_reg;
    assign vertex_color  = color_reg;
    assign vertex_alpha  = alpha_reg;
    assign last_triangle = last_reg;

    // The final triangle transaction returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_triangle |=> in_ready)
        else $error("block not idle after the final triangle");

    // The CORDIC unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_VEC_WAIT || state_reg == ST_ROT_WAIT))
        else $error("CORDIC completion outside a wait state");

    // The circle start point is captured only before the first wedge.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRIME |-> (wedge_reg == '0 && op_reg == OP_CIRCLE))
        else $error("circle start point captured out of sequence");

endmodule
